FILE: src/bmp24_stream_to_rgb565_macros.svh
// assertion macros used by the bmp24 stream decoder checker
`ifndef BMP24_STREAM_TO_RGB565_MACROS_SVH
`define BMP24_STREAM_TO_RGB565_MACROS_SVH

// same-cycle implication, disabled during reset
`define BMP_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("bmp24 decoder assertion failed");

// next-cycle implication, disabled during reset
`define BMP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("bmp24 decoder assertion failed");

`endif

FILE: src/bmp_pkg.sv
// types and constants for the bmp24 to rgb565 stream decoder
`default_nettype none

package bmp_pkg;

  // header layout
  localparam int unsigned HDR_LEN    = 34;
  localparam int unsigned HDR_LAST   = HDR_LEN - 1;
  localparam int unsigned OFFS_B0    = 10;
  localparam int unsigned OFFS_B1    = 11;
  localparam int unsigned OFFS_B2    = 12;
  localparam int unsigned OFFS_B3    = 13;
  localparam int unsigned WIDTH_B0   = 18;
  localparam int unsigned WIDTH_B1   = 19;
  localparam int unsigned HEIGHT_B0  = 22;
  localparam int unsigned HEIGHT_B1  = 23;
  localparam int unsigned PLANES_POS = 26;
  localparam int unsigned BPP_POS    = 28;

  localparam logic [7:0] SIG_LO      = 8'h42;
  localparam logic [7:0] SIG_HI      = 8'h4D;
  localparam logic [7:0] PLANES_WANT = 8'd1;
  localparam logic [7:0] BPP_WANT    = 8'd24;
  localparam logic [7:0] RED_MASK    = 8'hF8;
  localparam logic [7:0] GREEN_MASK  = 8'hFC;

  // configuration reset values
  localparam logic [14:0] SCREEN_W_RST = 15'd160;
  localparam logic [14:0] SCREEN_H_RST = 15'd128;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X = 2'd0,
    CFG_ORIGIN_Y = 2'd1,
    CFG_SCREEN_W = 2'd2,
    CFG_SCREEN_H = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_DRAIN  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_PIXEL       = 3'd0,
    ST_OFF_SCREEN  = 3'd1,
    ST_NOT_BITMAP  = 3'd2,
    ST_UNSUPPORTED = 3'd3,
    ST_BAD_OFFSET  = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [14:0]        screen_width;
    logic [14:0]        screen_height;
  } cfg_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [15:0]        color565;
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               image_done;
  } out_t;

endpackage

`default_nettype wire

FILE: src/bmp_cfg_regs.sv
// configuration registers of the bmp24 decoder
`default_nettype none

module bmp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  bmp_pkg::cfg_idx_e cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  output bmp_pkg::cfg_t     cfg_o
);
  import bmp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ORIGIN_X: cfg_d.origin_x      = $signed(cfg_wdata_i);
        CFG_ORIGIN_Y: cfg_d.origin_y      = $signed(cfg_wdata_i);
        CFG_SCREEN_W: cfg_d.screen_width  = cfg_wdata_i[14:0];
        CFG_SCREEN_H: cfg_d.screen_height = cfg_wdata_i[14:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.screen_width  <= SCREEN_W_RST;
      cfg_q.screen_height <= SCREEN_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: src/bmp_in_stage.sv
// input register of the bmp24 decoder
`default_nettype none

module bmp_in_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  bmp_pkg::in_t in_data_i,
  input  logic         advance_i,
  output logic         item_valid_o,
  output bmp_pkg::in_t item_o
);
  import bmp_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;
  logic load;

  // take a new request when empty or when the held one moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

`default_nettype wire

FILE: src/bmp_parser.sv
// header parser, pixel assembler and position counters of the bmp24 decoder
`default_nettype none

module bmp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bmp_pkg::cfg_t cfg_i,
  input  logic          go_i,
  input  bmp_pkg::in_t  item_i,
  output logic          res_valid_o,
  output bmp_pkg::out_t res_o
);
  import bmp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [5:0]  header_count_q, header_count_d;
  logic [31:0] byte_position_q, byte_position_d;
  logic [31:0] data_offset_q, data_offset_d;
  logic [15:0] image_width_q, image_width_d;
  logic [15:0] image_height_q, image_height_d;
  logic        format_ok_q, format_ok_d;
  logic [15:0] row_count_q, row_count_d;
  logic [15:0] column_count_q, column_count_d;
  logic [1:0]  byte_in_pixel_q, byte_in_pixel_d;
  logic [7:0]  held_blue_q, held_blue_d;
  logic [7:0]  held_green_q, held_green_d;
  logic [1:0]  pad_left_q, pad_left_d;

  logic [7:0]  b;
  logic [5:0]  n;
  logic        off_screen;
  logic [7:0]  want;
  logic        fmt_now;
  logic        do_pixel;
  logic        last_col;
  logic        last_row;
  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [15:0] color;

  assign b = item_i.file_byte;
  assign n = header_count_q;

  // origin must lie below the screen width and height
  assign off_screen = (cfg_i.origin_x >= $signed({1'b0, cfg_i.screen_width})) ||
                      (cfg_i.origin_y >= $signed({1'b0, cfg_i.screen_height}));

  // expected value of a format byte
  always_comb begin
    if (n == 6'(PLANES_POS)) begin
      want = PLANES_WANT;
    end else if (n == 6'(BPP_POS)) begin
      want = BPP_WANT;
    end else begin
      want = 8'd0;
    end
  end
  assign fmt_now = format_ok_q && (b == want);

  // pixel assembly and screen position
  assign color    = {(b & RED_MASK), 8'd0} | {5'd0, (held_green_q & GREEN_MASK), 3'd0} |
                    {11'd0, held_blue_q[7:3]};
  assign pos_x    = cfg_i.origin_x + column_count_q;
  assign pos_y    = cfg_i.origin_y + image_height_q - 16'd1 - row_count_q;
  assign last_col = ({1'b0, column_count_q} + 17'd1) >= {1'b0, image_width_q};
  assign last_row = ({1'b0, row_count_q} + 17'd1) >= {1'b0, image_height_q};

  // next state and result for one byte
  always_comb begin
    phase_d         = phase_q;
    header_count_d  = header_count_q;
    byte_position_d = byte_position_q;
    data_offset_d   = data_offset_q;
    image_width_d   = image_width_q;
    image_height_d  = image_height_q;
    format_ok_d     = format_ok_q;
    row_count_d     = row_count_q;
    column_count_d  = column_count_q;
    byte_in_pixel_d = byte_in_pixel_q;
    held_blue_d     = held_blue_q;
    held_green_d    = held_green_q;
    pad_left_d      = pad_left_q;
    res_valid_o     = 1'b0;
    res_o           = '0;
    do_pixel        = 1'b0;

    if (go_i) begin
      byte_position_d = byte_position_q + 32'd1;

      unique case (phase_q)
        PH_HEADER: begin
          header_count_d = n + 6'd1;
          if (n == 6'd0) begin
            if (off_screen) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_OFF_SCREEN;
              phase_d      = PH_DRAIN;
            end else begin
              held_blue_d = b;
            end
          end else if (n == 6'd1) begin
            if ((held_blue_q != SIG_LO) || (b != SIG_HI)) begin
              res_valid_o  = 1'b1;
              res_o.status = ST_NOT_BITMAP;
              phase_d      = PH_DRAIN;
            end else begin
              held_blue_d = 8'd0;
            end
          end else begin
            // little-endian header fields
            if (n == 6'(OFFS_B0)) data_offset_d[7:0]   = b;
            if (n == 6'(OFFS_B1)) data_offset_d[15:8]  = b;
            if (n == 6'(OFFS_B2)) data_offset_d[23:16] = b;
            if (n == 6'(OFFS_B3)) data_offset_d[31:24] = b;
            if (n == 6'(WIDTH_B0))  image_width_d[7:0]   = b;
            if (n == 6'(WIDTH_B1))  image_width_d[15:8]  = b;
            if (n == 6'(HEIGHT_B0)) image_height_d[7:0]  = b;
            if (n == 6'(HEIGHT_B1)) image_height_d[15:8] = b;
            if (n >= 6'(PLANES_POS)) format_ok_d = fmt_now;

            // end of header: format, offset and size decide the next phase
            if (n == 6'(HDR_LAST)) begin
              if (!fmt_now) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_UNSUPPORTED;
                phase_d      = PH_DRAIN;
              end else if (data_offset_q < 32'(HDR_LEN)) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_BAD_OFFSET;
                phase_d      = PH_DRAIN;
              end else if ((image_width_q == 16'd0) || (image_height_q == 16'd0)) begin
                phase_d = PH_DRAIN;
              end else if (data_offset_q == 32'(HDR_LEN)) begin
                phase_d = PH_PIXEL;
              end else begin
                phase_d = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (byte_position_q >= data_offset_q) begin
            phase_d  = PH_PIXEL;
            do_pixel = 1'b1;
          end
        end
        PH_PIXEL: begin
          do_pixel = 1'b1;
        end
        PH_PAD: begin
          pad_left_d = pad_left_q - 2'd1;
          if (pad_left_d == 2'd0) begin
            phase_d = PH_PIXEL;
          end
        end
        PH_DRAIN: begin
        end
        default: begin
        end
      endcase

      // blue, green, then red completes a pixel
      if (do_pixel) begin
        if (byte_in_pixel_q == 2'd0) begin
          held_blue_d     = b;
          byte_in_pixel_d = 2'd1;
        end else if (byte_in_pixel_q == 2'd1) begin
          held_green_d    = b;
          byte_in_pixel_d = 2'd2;
        end else begin
          byte_in_pixel_d  = 2'd0;
          res_valid_o      = 1'b1;
          res_o.status     = ST_PIXEL;
          res_o.color565   = color;
          res_o.pixel_x    = $signed(pos_x);
          res_o.pixel_y    = $signed(pos_y);
          res_o.image_done = last_col && last_row;
          if (last_col) begin
            column_count_d = 16'd0;
            if (last_row) begin
              phase_d = PH_DRAIN;
            end else begin
              row_count_d = row_count_q + 16'd1;
              // rows pad to four bytes: pad count equals width mod 4
              pad_left_d  = image_width_q[1:0];
              phase_d     = (image_width_q[1:0] != 2'd0) ? PH_PAD : PH_PIXEL;
            end
          end else begin
            column_count_d = column_count_q + 16'd1;
          end
        end
      end

      // last byte of the file restarts the parser
      if (item_i.final_byte) begin
        phase_d         = PH_HEADER;
        header_count_d  = '0;
        byte_position_d = '0;
        data_offset_d   = '0;
        image_width_d   = '0;
        image_height_d  = '0;
        format_ok_d     = 1'b1;
        row_count_d     = '0;
        column_count_d  = '0;
        byte_in_pixel_d = '0;
        held_blue_d     = '0;
        held_green_d    = '0;
        pad_left_d      = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HEADER;
      header_count_q  <= '0;
      byte_position_q <= '0;
      data_offset_q   <= '0;
      image_width_q   <= '0;
      image_height_q  <= '0;
      format_ok_q     <= 1'b1;
      row_count_q     <= '0;
      column_count_q  <= '0;
      byte_in_pixel_q <= '0;
      held_blue_q     <= '0;
      held_green_q    <= '0;
      pad_left_q      <= '0;
    end else begin
      phase_q         <= phase_d;
      header_count_q  <= header_count_d;
      byte_position_q <= byte_position_d;
      data_offset_q   <= data_offset_d;
      image_width_q   <= image_width_d;
      image_height_q  <= image_height_d;
      format_ok_q     <= format_ok_d;
      row_count_q     <= row_count_d;
      column_count_q  <= column_count_d;
      byte_in_pixel_q <= byte_in_pixel_d;
      held_blue_q     <= held_blue_d;
      held_green_q    <= held_green_d;
      pad_left_q      <= pad_left_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/bmp_out_stage.sv
// result register of the bmp24 decoder
`default_nettype none

module bmp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  bmp_pkg::out_t res_i,
  output logic          can_take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bmp_pkg::out_t out_data_o
);
  import bmp_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // room when empty or when the held result leaves this cycle
  assign can_take_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

FILE: src/bmp24_stream_to_rgb565.sv
// a byte request is held in the input register, and its result is captured in the result register
// one file byte per cycle while the result register has room, pixels out every third byte of pixel data
// the input register and the result register decouple the two sides
// reset (async, active low) clears the parser to the header phase and loads
// default registers: origin 0,0 and a 160 by 128 screen
// a final byte restarts the parser after it is processed; registers are kept
`default_nettype none

module bmp24_stream_to_rgb565 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bmp_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bmp_pkg::out_t     out_data_o,
  input  logic              cfg_we_i,
  input  bmp_pkg::cfg_idx_e cfg_index_i,
  input  logic [15:0]       cfg_wdata_i
);
  import bmp_pkg::*;

  cfg_t cfg;
  in_t  item;
  out_t res;
  logic item_valid;
  logic res_valid;
  logic can_take;
  logic advance;

  // a held byte moves on whenever the result register has room
  assign advance = item_valid && can_take;

  bmp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  bmp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  bmp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .go_i       (advance),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  bmp_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && res_valid),
    .res_i      (res),
    .can_take_o (can_take),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

FILE: src/bmp_checker.sv
// port-level checker for the bmp24 decoder and its bind
`default_nettype none
`include "bmp24_stream_to_rgb565_macros.svh"

module bmp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input bmp_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input bmp_pkg::out_t out_data_o
);
  import bmp_pkg::*;

  logic in_stall;
  logic out_stall;
  logic out_err;
  logic err_payload_zero;
  logic out_room;

  assign in_stall         = in_valid_i && !in_ready_o;
  assign out_stall        = out_valid_o && !out_ready_i;
  assign out_err          = out_valid_o && (out_data_o.status != ST_PIXEL);
  assign err_payload_zero = (out_data_o.color565 == 16'd0) && (out_data_o.pixel_x == 16'sd0) &&
                            (out_data_o.pixel_y == 16'sd0) && !out_data_o.image_done;
  assign out_room         = !out_valid_o || out_ready_i;

  // a waiting request stays offered and unchanged
  `BMP_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_data_i))

  // a stalled result stays offered and unchanged
  `BMP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_data_o))

  // error results carry an all-zero payload
  `BMP_ASSERT_NOW(a_err_zero, clk_i, rst_ni, out_err, err_payload_zero)

  // input never blocks while the result side has room
  `BMP_ASSERT_NOW(a_in_free, clk_i, rst_ni, out_room, in_ready_o)

endmodule

bind bmp24_stream_to_rgb565 bmp_checker u_bmp_checker (.*);

`default_nettype wire
